>>> hdl/njs_pkg.sv
// package for the nonpreemptive job scheduler
// beat types and policy codes, no dependencies
`default_nettype none
package njs_pkg;
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_PRTY = 2'd2;
  localparam logic [1:0] MODE_LIFO = 2'd3;

  typedef struct packed {
    logic [15:0] arrival_time;
    logic [11:0] burst_length;
    logic [7:0]  priority_level;
    logic        last_job;
  } job_in_t;

  typedef struct packed {
    logic [6:0]  job_id;
    logic [18:0] start_time;
    logic [18:0] end_time;
    logic [18:0] wait_time;
    logic        last_result;
  } job_out_t;

  // data handed from cell to cell during a scan
  typedef struct packed {
    logic        found;
    logic [6:0]  idx;
    logic [15:0] arr;
    logic [11:0] burst;
    logic [7:0]  prio;
    logic        pend;
    logic [15:0] min_arr;
  } scan_t;
endpackage
`default_nettype wire

>>> hdl/njs_cell.sv
// one job slot of the scheduler chain: stores a job and compares it
// against the running best that passes through; uses njs_pkg
`default_nettype none
module njs_cell import njs_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire job_in_t     job_i,
  input  wire logic        clr_i,
  input  wire logic        done_set_i,
  input  wire logic [6:0]  done_idx_i,
  input  wire logic        active_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [18:0] time_i,
  input  wire scan_t       scan_i,
  output scan_t            scan_o
);
  logic [15:0] arr_q;
  logic [11:0] burst_q;
  logic [7:0]  prio_q;
  logic        done_q;
  logic        ready;
  logic        beats;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      arr_q   <= job_i.arrival_time;
      burst_q <= job_i.burst_length;
      prio_q  <= job_i.priority_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (clr_i || load_i) begin
      done_q <= 1'b0;
    end else if (done_set_i && done_idx_i == 7'(Idx)) begin
      done_q <= 1'b1;
    end
  end

  always_comb begin
    ready = active_i && !done_q && ({3'b0, arr_q} <= time_i);
    case (mode_i)
      MODE_FIFO: beats = arr_q < scan_i.arr;
      MODE_SJF:  beats = burst_q < scan_i.burst ||
                         (burst_q == scan_i.burst && arr_q < scan_i.arr);
      MODE_PRTY: beats = prio_q < scan_i.prio ||
                         (prio_q == scan_i.prio && arr_q < scan_i.arr);
      default:   beats = arr_q > scan_i.arr;
    endcase
    scan_o = scan_i;
    if (ready && (!scan_i.found || beats)) begin
      scan_o.found = 1'b1;
      scan_o.idx   = 7'(Idx);
      scan_o.arr   = arr_q;
      scan_o.burst = burst_q;
      scan_o.prio  = prio_q;
    end
    if (active_i && !done_q && (!scan_i.pend || arr_q < scan_i.min_arr)) begin
      scan_o.pend    = 1'b1;
      scan_o.min_arr = arr_q;
    end
  end
endmodule
`default_nettype wire

>>> hdl/nonpreemptive_job_scheduler_top.sv
// top level of the nonpreemptive job scheduler: load control, pick
// sequencer and output register; uses njs_pkg and njs_cell
`default_nettype none
// Usage: jobs enter one beat per cycle on the input channel (valid/stall)
// and fill the cell chain in load order; a full chain drops further jobs.
// The beat with last_job set starts scheduling: the input stalls until the
// whole set is emitted. Each pick takes one pass through the chain: the
// registered running best moves from cell to cell, a cell per cycle, and a
// pick ends with its emit state. A pass that finds nothing ready jumps time
// forward and adds one more pass. Results are held in an output register;
// while it holds a stalled beat the sequencer waits in its emit state.
// The policy register is written by cfg_we_i; the user must write it only
// while idle, which the block itself does not enforce. It resets to FIFO.
// Reset clears all done flags, counters and the output valid.
module nonpreemptive_job_scheduler_top import njs_pkg::*; #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire job_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output job_out_t      out_data_o
);
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  mode_q;
  logic [1:0]  st_q;
  logic [6:0]  cnt_q;
  logic [6:0]  iss_q;
  logic [CW-1:0] pos_q;
  logic [18:0] time_q;
  logic [15:0] arr0_q;
  scan_t       acc_q;
  scan_t       chain [MAX_JOBS];
  scan_t       pick;
  logic        in_acc;
  logic        done_set;
  logic        clr;
  logic [18:0] start_t;

  assign in_stall_o = (st_q != ST_LOAD);
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    pick = '0;
    for (int k = 0; k < MAX_JOBS; k++) begin
      if (pos_q == CW'(k)) pick = chain[k];
    end
  end

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    logic cell_ld;
    assign cell_ld = in_acc && cnt_q == 7'(g);
    njs_cell #(.Idx(g)) u_cell (
      .clk_i, .rst_ni,
      .load_i(cell_ld), .job_i(in_data_i),
      .clr_i(clr), .done_set_i(done_set), .done_idx_i(acc_q.idx),
      .active_i(7'(g) < cnt_q), .mode_i(mode_q), .time_i(time_q),
      .scan_i((pos_q == CW'(g)) ? (g == 0 ? scan_t'('0) : acc_q) : scan_t'('0)),
      .scan_o(chain[g])
    );
  end

  assign start_t = time_q;
  assign done_set = (st_q == ST_EMIT) && !(out_valid_o && out_stall_i);
  assign clr = done_set && (iss_q + 7'd1 == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FIFO;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD;
      cnt_q <= '0;
      iss_q <= '0;
      pos_q <= '0;
      time_q <= '0;
      arr0_q <= '0;
      acc_q <= '0;
      out_valid_o <= 1'b0;
      out_data_o <= '0;
    end else begin
      if (done_set) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (st_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (cnt_q == '0) arr0_q <= in_data_i.arrival_time;
            if (cnt_q < 7'(MAX_JOBS)) cnt_q <= cnt_q + 7'd1;
            if (in_data_i.last_job) begin
              st_q <= ST_SCAN;
              pos_q <= '0;
              iss_q <= '0;
              time_q <= {3'b0, (cnt_q == '0) ? in_data_i.arrival_time : arr0_q};
            end
          end
        end
        ST_SCAN: begin
          acc_q <= pick;
          if (pos_q == CW'(MAX_JOBS - 1)) begin
            pos_q <= '0;
            if (pick.found) begin
              st_q <= ST_EMIT;
            end else begin
              time_q <= {3'b0, pick.min_arr};
            end
          end else begin
            pos_q <= pos_q + CW'(1);
          end
        end
        ST_EMIT: begin
          if (done_set) begin
            out_data_o.job_id <= acc_q.idx + 7'd1;
            out_data_o.start_time <= start_t;
            out_data_o.end_time <= start_t + {7'b0, acc_q.burst};
            out_data_o.wait_time <= start_t - {3'b0, acc_q.arr};
            out_data_o.last_result <= clr;
            if (clr) begin
              st_q <= ST_LOAD;
              cnt_q <= '0;
              iss_q <= '0;
              time_q <= '0;
            end else begin
              st_q <= ST_SCAN;
              time_q <= start_t + {7'b0, acc_q.burst};
              iss_q <= iss_q + 7'd1;
            end
          end
        end
        default: st_q <= ST_LOAD;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_LOAD |-> !in_acc) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result lost under stall");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(MAX_JOBS)) else $error("job count overflow");
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_LOAD |-> iss_q < cnt_q) else $error("issued past loaded");
endmodule
`default_nettype wire

>>> test/nonpreemptive_job_scheduler_top_tb.sv
// testbench for the nonpreemptive job scheduler top level
// predicts each schedule in a scoreboard class and checks every result beat
// depends on njs_pkg and nonpreemptive_job_scheduler_top
`default_nettype none
module nonpreemptive_job_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import njs_pkg::*;

  localparam int unsigned NJOBS = 32;

  class sched_board;
    logic [15:0] arr_q[$];
    logic [11:0] bur_q[$];
    logic [7:0]  pri_q[$];
    job_out_t    sched_q[$];
    logic [1:0]  mode;
    int          errors;

    function new();
      mode = MODE_FIFO;
      errors = 0;
    endfunction

    function bit wins(int a, int b);
      case (mode)
        MODE_FIFO: return arr_q[a] < arr_q[b];
        MODE_SJF: return bur_q[a] < bur_q[b] || (bur_q[a] == bur_q[b] && arr_q[a] < arr_q[b]);
        MODE_PRTY: return pri_q[a] < pri_q[b] || (pri_q[a] == pri_q[b] && arr_q[a] < arr_q[b]);
        default: return arr_q[a] > arr_q[b];
      endcase
    endfunction

    function void note_job(job_in_t j);
      int n, best, issued;
      logic [18:0] now, nxt;
      bit ran[NJOBS];
      job_out_t r;
      if (arr_q.size() < NJOBS) begin
        arr_q.push_back(j.arrival_time);
        bur_q.push_back(j.burst_length);
        pri_q.push_back(j.priority_level);
      end
      if (!j.last_job) return;
      n = arr_q.size();
      foreach (ran[i]) ran[i] = 0;
      now = arr_q[0];
      issued = 0;
      while (issued < n) begin
        best = -1;
        for (int i = 0; i < n; i++)
          if (!ran[i] && arr_q[i] <= now && (best < 0 || wins(i, best))) best = i;
        if (best < 0) begin
          nxt = '1;
          for (int i = 0; i < n; i++)
            if (!ran[i] && arr_q[i] < nxt) nxt = arr_q[i];
          now = nxt;
        end else begin
          ran[best] = 1;
          r.job_id = 7'(best + 1);
          r.start_time = now;
          r.end_time = now + bur_q[best];
          r.wait_time = now - arr_q[best];
          r.last_result = (issued + 1 == n);
          sched_q.push_back(r);
          now = r.end_time;
          issued++;
        end
      end
      arr_q.delete();
      bur_q.delete();
      pri_q.delete();
    endfunction

    function void check_result(job_out_t got);
      job_out_t e;
      if (sched_q.size() == 0) begin
        $error("unexpected result beat job_id %0d", got.job_id);
        errors++;
        return;
      end
      e = sched_q.pop_front();
      if (got.job_id !== e.job_id) begin
        $error("job_id exp %0d got %0d", e.job_id, got.job_id); errors++;
      end
      if (got.start_time !== e.start_time) begin
        $error("start_time exp %0d got %0d", e.start_time, got.start_time); errors++;
      end
      if (got.end_time !== e.end_time) begin
        $error("end_time exp %0d got %0d", e.end_time, got.end_time); errors++;
      end
      if (got.wait_time !== e.wait_time) begin
        $error("wait_time exp %0d got %0d", e.wait_time, got.wait_time); errors++;
      end
      if (got.last_result !== e.last_result) begin
        $error("last_result exp %0d got %0d", e.last_result, got.last_result); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  job_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  job_out_t out_data_o;
  logic hold_off = 0;
  int cycles = 0;
  int burst_left = 0;
  sched_board sb = new();

  nonpreemptive_job_scheduler_top #(.MAX_JOBS(NJOBS)) dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("nonpreemptive_job_scheduler_top_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= hold_off || ($urandom_range(0, 3) == 0 && cycles[9:8] != 0);
  end

  task automatic send_job(job_in_t j);
    if (burst_left == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(0, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i <= 1;
    in_data_i <= j;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_job(j);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.sched_q.size() != 0) @(posedge clk_i);
    repeat (2 * NJOBS + 8) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m);
    cfg_we_i <= 1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.mode = m;
  endtask

  function automatic job_in_t rand_job(bit last);
    job_in_t j;
    j.arrival_time = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    j.burst_length = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(1, 60));
    j.priority_level = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
    j.last_job = last;
    return j;
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_job(rand_job(i == n - 1));
  endtask

  initial begin
    job_in_t j;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, ties, idle gap, single job
    j = '{16'hffff, 12'hfff, 8'hff, 1'b1};
    send_job(j);
    drain();
    j = '{16'd0, 12'd1, 8'd1, 1'b0}; send_job(j);
    j = '{16'd0, 12'd1, 8'd1, 1'b0}; send_job(j);
    j = '{16'd5000, 12'd0, 8'd0, 1'b0}; send_job(j);
    j = '{16'd2, 12'hfff, 8'hff, 1'b1}; send_job(j);
    drain();
    for (int m = 0; m < 4; m++) begin
      set_mode(m[1:0]);
      j = '{16'd10, 12'd30, 8'd3, 1'b0}; send_job(j);
      j = '{16'd12, 12'd5, 8'd1, 1'b0}; send_job(j);
      j = '{16'd11, 12'd5, 8'd2, 1'b0}; send_job(j);
      j = '{16'd12, 12'd20, 8'd1, 1'b1}; send_job(j);
      drain();
    end
    // store overflow with long receiver hold-off
    set_mode(MODE_SJF);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      send_set(NJOBS + 3);
    join
    drain();
    for (int k = 0; k < 24; k++) begin
      if (k % 4 == 0) set_mode(2'($urandom));
      send_set((k % 7 == 0) ? NJOBS : $urandom_range(1, 8));
      if (k % 4 == 3) drain();
    end
    drain();
    if (sb.errors == 0 && sb.sched_q.size() == 0)
      $display("nonpreemptive_job_scheduler_top_tb: done, clean");
    else
      $display("nonpreemptive_job_scheduler_top_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
